@@ hw/rtl/double_ended_queue_unit_macros.svh @@
// Assertion helpers for the deque unit. Each expects clk and rst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/deq_pkg.sv @@
`timescale 1ns / 1ps
package deq_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W  = 3;
  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int OCC_W = 7;
  localparam int ST_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_WRITE      = 3'd5,
    OP_INSERT     = 3'd6,
    OP_ERASE      = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Logical index that feeds the store address.
  typedef enum logic [2:0] {
    AS_POS,
    AS_CNT,
    AS_CNT_M1,
    AS_HEAD,
    AS_HEAD_M1,
    AS_IDX,
    AS_IDX_M1,
    AS_IDX_P1
  } addr_sel_t;

  typedef enum logic {
    WD_IN,
    WD_RAM
  } wd_sel_t;

  typedef enum logic [1:0] {
    VS_ZERO,
    VS_RAM,
    VS_SAVED
  } val_sel_t;

  typedef struct packed {
    logic      load;
    logic      rd_en;
    logic      wr_en;
    addr_sel_t addr_sel;
    wd_sel_t   wd_sel;
    logic      idx_load_count;
    logic      idx_load_pos;
    logic      idx_inc;
    logic      idx_dec;
    logic      head_inc;
    logic      head_dec;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      save;
    logic      emit;
    val_sel_t  val_sel;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic err;
    logic idx_at_pos;
    logic idx_at_last;
  } stat_t;

endpackage

@@ hw/rtl/deq_ram.sv @@
`timescale 1ns / 1ps
module deq_ram #(
  parameter int WIDTH = deq_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = deq_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/deq_ctrl.sv @@
`timescale 1ns / 1ps
module deq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  deq_pkg::stat_t stat,
  output deq_pkg::cmd_t  cmd,
  output logic           out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_INS_LOOP,
    S_INS_WR,
    S_ERS_LOOP,
    S_ERS_WR
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        if (stat.err) begin
          cmd.emit    = 1'b1;
          cmd.val_sel = deq_pkg::VS_ZERO;
        end else begin
          unique case (stat.op)
            deq_pkg::OP_PUSH_BACK: begin
              cmd.wr_en    = 1'b1;
              cmd.addr_sel = deq_pkg::AS_CNT;
              cmd.wd_sel   = deq_pkg::WD_IN;
              cmd.cnt_inc  = 1'b1;
              cmd.emit     = 1'b1;
            end
            deq_pkg::OP_PUSH_FRONT: begin
              cmd.wr_en    = 1'b1;
              cmd.addr_sel = deq_pkg::AS_HEAD_M1;
              cmd.wd_sel   = deq_pkg::WD_IN;
              cmd.head_dec = 1'b1;
              cmd.cnt_inc  = 1'b1;
              cmd.emit     = 1'b1;
            end
            deq_pkg::OP_POP_BACK: begin
              cmd.rd_en    = 1'b1;
              cmd.addr_sel = deq_pkg::AS_CNT_M1;
              state_nxt    = S_RD_WAIT;
            end
            deq_pkg::OP_POP_FRONT: begin
              cmd.rd_en    = 1'b1;
              cmd.addr_sel = deq_pkg::AS_HEAD;
              state_nxt    = S_RD_WAIT;
            end
            deq_pkg::OP_READ: begin
              cmd.rd_en    = 1'b1;
              cmd.addr_sel = deq_pkg::AS_POS;
              state_nxt    = S_RD_WAIT;
            end
            deq_pkg::OP_WRITE: begin
              cmd.wr_en    = 1'b1;
              cmd.addr_sel = deq_pkg::AS_POS;
              cmd.wd_sel   = deq_pkg::WD_IN;
              cmd.emit     = 1'b1;
            end
            deq_pkg::OP_INSERT: begin
              cmd.idx_load_count = 1'b1;
              state_nxt          = S_INS_LOOP;
            end
            deq_pkg::OP_ERASE: begin
              cmd.rd_en        = 1'b1;
              cmd.addr_sel     = deq_pkg::AS_POS;
              cmd.idx_load_pos = 1'b1;
              state_nxt        = S_RD_WAIT;
            end
            default: begin
              cmd.emit = 1'b1;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        state_nxt = S_IDLE;
        unique case (stat.op)
          deq_pkg::OP_POP_BACK: begin
            cmd.emit    = 1'b1;
            cmd.val_sel = deq_pkg::VS_RAM;
            cmd.cnt_dec = 1'b1;
          end
          deq_pkg::OP_POP_FRONT: begin
            cmd.emit     = 1'b1;
            cmd.val_sel  = deq_pkg::VS_RAM;
            cmd.head_inc = 1'b1;
            cmd.cnt_dec  = 1'b1;
          end
          deq_pkg::OP_ERASE: begin
            cmd.save  = 1'b1;
            state_nxt = S_ERS_LOOP;
          end
          default: begin
            cmd.emit    = 1'b1;
            cmd.val_sel = deq_pkg::VS_RAM;
          end
        endcase
      end
      S_INS_LOOP: begin
        // Shift done: drop the new element into the gap.
        if (stat.idx_at_pos) begin
          cmd.wr_en    = 1'b1;
          cmd.addr_sel = deq_pkg::AS_IDX;
          cmd.wd_sel   = deq_pkg::WD_IN;
          cmd.cnt_inc  = 1'b1;
          cmd.emit     = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.addr_sel = deq_pkg::AS_IDX_M1;
          state_nxt    = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.addr_sel = deq_pkg::AS_IDX;
        cmd.wd_sel   = deq_pkg::WD_RAM;
        cmd.idx_dec  = 1'b1;
        state_nxt    = S_INS_LOOP;
      end
      S_ERS_LOOP: begin
        if (stat.idx_at_last) begin
          cmd.cnt_dec = 1'b1;
          cmd.emit    = 1'b1;
          cmd.val_sel = deq_pkg::VS_SAVED;
          state_nxt   = S_IDLE;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.addr_sel = deq_pkg::AS_IDX_P1;
          state_nxt    = S_ERS_WR;
        end
      end
      S_ERS_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.addr_sel = deq_pkg::AS_IDX;
        cmd.wd_sel   = deq_pkg::WD_RAM;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_ERS_LOOP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/deq_dp.sv @@
`timescale 1ns / 1ps
module deq_dp #(
  parameter int CAPACITY   = deq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [deq_pkg::OP_W-1:0]    in_opcode,
  input  logic [deq_pkg::POS_W-1:0]   in_position,
  input  logic [deq_pkg::VAL_W-1:0]   in_value_in,
  input  deq_pkg::cmd_t               cmd,
  output deq_pkg::stat_t              stat,
  output logic [deq_pkg::VAL_W-1:0]   out_value_out,
  output logic [deq_pkg::OCC_W-1:0]   out_occupancy,
  output logic [deq_pkg::ST_W-1:0]    out_status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > deq_pkg::POS_W) ? CW : deq_pkg::POS_W;
  localparam int SW = PW + 1;

  localparam logic [AW-1:0] HEAD_MAX = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_SUM  = SW'(CAPACITY);

  deq_pkg::op_t     op_r;
  deq_pkg::status_t err_code;
  deq_pkg::status_t out_status_r;
  logic [PW-1:0]    pos_r;
  logic [DATA_WIDTH-1:0] val_r, saved_r, wr_data, ram_rdata;
  logic [AW-1:0]    head_r, head_nxt, head_dec, addr;
  logic [CW-1:0]    count_r, count_nxt;
  logic [PW-1:0]    idx_r, idx_nxt, cnt_ext, logical;
  logic [SW-1:0]    slot_sum, slot_wrap;
  logic [deq_pkg::VAL_W-1:0] value_sel, out_value_r;
  logic [deq_pkg::OCC_W-1:0] out_occ_r;
  logic             full, empty;

  assign cnt_ext = PW'(count_r);
  assign full    = (count_r == CAP_CNT);
  assign empty   = (count_r == '0);

  always_comb begin
    err_code = deq_pkg::ST_OK;
    unique case (op_r)
      deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
        if (full) err_code = deq_pkg::ST_FULL;
      end
      deq_pkg::OP_POP_BACK, deq_pkg::OP_POP_FRONT: begin
        if (empty) err_code = deq_pkg::ST_EMPTY;
      end
      deq_pkg::OP_READ, deq_pkg::OP_WRITE, deq_pkg::OP_ERASE: begin
        if (pos_r >= cnt_ext) err_code = deq_pkg::ST_RANGE;
      end
      deq_pkg::OP_INSERT: begin
        priority if (full) err_code = deq_pkg::ST_FULL;
        else if (pos_r > cnt_ext) err_code = deq_pkg::ST_RANGE;
        else err_code = deq_pkg::ST_OK;
      end
      default: err_code = deq_pkg::ST_OK;
    endcase
  end

  assign stat.op          = op_r;
  assign stat.err         = (err_code != deq_pkg::ST_OK);
  assign stat.idx_at_pos  = (idx_r == pos_r);
  assign stat.idx_at_last = ((idx_r + PW'(1)) == cnt_ext);

  // Logical index to physical slot: head plus index, wrapped once.
  always_comb begin
    unique case (cmd.addr_sel)
      deq_pkg::AS_POS:    logical = pos_r;
      deq_pkg::AS_CNT:    logical = cnt_ext;
      deq_pkg::AS_CNT_M1: logical = cnt_ext - PW'(1);
      deq_pkg::AS_IDX:    logical = idx_r;
      deq_pkg::AS_IDX_M1: logical = idx_r - PW'(1);
      deq_pkg::AS_IDX_P1: logical = idx_r + PW'(1);
      default:            logical = '0;
    endcase
  end

  assign slot_sum  = SW'(head_r) + SW'(logical);
  assign slot_wrap = (slot_sum >= CAP_SUM) ? (slot_sum - CAP_SUM) : slot_sum;
  assign head_dec  = (head_r == '0) ? HEAD_MAX : (head_r - AW'(1));
  assign addr      = (cmd.addr_sel == deq_pkg::AS_HEAD_M1) ? head_dec : AW'(slot_wrap);

  assign wr_data = (cmd.wd_sel == deq_pkg::WD_RAM) ? ram_rdata : val_r;

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_deq_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (addr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    head_nxt = head_r;
    if (cmd.head_dec) begin
      head_nxt = head_dec;
    end else if (cmd.head_inc) begin
      head_nxt = (head_r == HEAD_MAX) ? '0 : (head_r + AW'(1));
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    priority if (cmd.idx_load_count) idx_nxt = cnt_ext;
    else if (cmd.idx_load_pos) idx_nxt = pos_r;
    else if (cmd.idx_inc) idx_nxt = idx_r + PW'(1);
    else if (cmd.idx_dec) idx_nxt = idx_r - PW'(1);
    else idx_nxt = idx_r;
  end

  always_comb begin
    unique case (cmd.val_sel)
      deq_pkg::VS_RAM:   value_sel = deq_pkg::VAL_W'(ram_rdata);
      deq_pkg::VS_SAVED: value_sel = deq_pkg::VAL_W'(saved_r);
      default:           value_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      op_r  <= deq_pkg::op_t'(in_opcode);
      pos_r <= PW'(in_position);
      val_r <= DATA_WIDTH'(in_value_in);
    end
    if (cmd.save) begin
      saved_r <= ram_rdata;
    end
    if (cmd.emit) begin
      out_value_r  <= value_sel;
      out_occ_r    <= deq_pkg::OCC_W'(count_nxt);
      out_status_r <= err_code;
    end
  end

  assign out_value_out = out_value_r;
  assign out_occupancy = out_occ_r;
  assign out_status    = out_status_r;

endmodule

@@ hw/rtl/double_ended_queue_unit.sv @@
`timescale 1ns / 1ps
// Double-ended queue unit: a fixed-capacity deque held in a circular RAM.
// Command channel: drive in_opcode, in_position and in_value_in with start;
// the command is taken on a clock edge where start is high and busy is low.
// Busy stays high until the command has finished, so one command runs at a
// time. Each command gives one result: out_valid pulses for one cycle with
// out_value_out, out_occupancy and out_status. There is no backpressure, so
// the consumer must capture the result in that cycle.
// Push, write, and any command rejected with an error status finish from the
// decode state; pop and read first wait for the registered RAM read. Insert
// shifts (occupancy - position) elements before writing the new one; erase
// reads the element at the position, then shifts (occupancy - position - 1)
// elements down before giving it back.
// Busy drops in the cycle out_valid rises, so a new command may follow at
// once. Insert and erase move one element at a time through the single
// RAM (read the neighbor, then write it back one slot over).
// Reset (rst_n low, synchronous) empties the queue and returns the head to
// slot zero; RAM contents are not cleared, and none is read before written.
module double_ended_queue_unit #(
  parameter int CAPACITY   = deq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [deq_pkg::OP_W-1:0]  in_opcode,
  input  logic [deq_pkg::POS_W-1:0] in_position,
  input  logic [deq_pkg::VAL_W-1:0] in_value_in,
  output logic                      out_valid,
  output logic [deq_pkg::VAL_W-1:0] out_value_out,
  output logic [deq_pkg::OCC_W-1:0] out_occupancy,
  output logic [deq_pkg::ST_W-1:0]  out_status
);

  deq_pkg::cmd_t  cmd;
  deq_pkg::stat_t stat;

  deq_ctrl u_deq_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .stat      (stat),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  deq_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_deq_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_opcode     (in_opcode),
    .in_position   (in_position),
    .in_value_in   (in_value_in),
    .cmd           (cmd),
    .stat          (stat),
    .out_value_out (out_value_out),
    .out_occupancy (out_occupancy),
    .out_status    (out_status)
  );

endmodule

@@ hw/rtl/deq_chk.sv @@
`timescale 1ns / 1ps
`include "double_ended_queue_unit_macros.svh"
module deq_chk #(
  parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [deq_pkg::VAL_W-1:0] out_value_out,
  input logic [deq_pkg::OCC_W-1:0] out_occupancy,
  input logic [deq_pkg::ST_W-1:0]  out_status
);

  `DEQ_ASSERT_NEXT(a_busy_after_transfer, start && !busy, busy, "busy not set after transfer")
  `DEQ_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `DEQ_ASSERT_NOW(a_err_value_zero, out_valid && (out_status != deq_pkg::ST_OK), out_value_out == '0, "nonzero value on error")
  `DEQ_ASSERT_NOW(a_full_occ, out_valid && (out_status == deq_pkg::ST_FULL), out_occupancy == deq_pkg::OCC_W'(CAPACITY), "full status with room left")
  `DEQ_ASSERT_NOW(a_empty_occ, out_valid && (out_status == deq_pkg::ST_EMPTY), out_occupancy == '0, "empty status on nonempty queue")

endmodule

bind double_ended_queue_unit deq_chk #(
  .CAPACITY (CAPACITY)
) u_deq_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_value_out (out_value_out),
  .out_occupancy (out_occupancy),
  .out_status    (out_status)
);

@@ sim/double_ended_queue_unit_checker.sv @@
`timescale 1ns / 1ps
module double_ended_queue_unit_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [deq_pkg::OP_W-1:0]  in_opcode,
  input  logic [deq_pkg::POS_W-1:0] in_position,
  input  logic [deq_pkg::VAL_W-1:0] in_value_in,
  input  logic                      out_valid,
  input  logic [deq_pkg::VAL_W-1:0] out_value_out,
  input  logic [deq_pkg::OCC_W-1:0] out_occupancy,
  input  logic [deq_pkg::ST_W-1:0]  out_status,
  output int                        mismatches,
  output int                        outstanding
);

  typedef struct packed {
    logic [deq_pkg::VAL_W-1:0] value;
    logic [deq_pkg::OCC_W-1:0] occupancy;
    deq_pkg::status_t          status;
  } deque_result_t;

  localparam logic [deq_pkg::OCC_W-1:0] FULL_COUNT = deq_pkg::OCC_W'(deq_pkg::CAPACITY_DEF);

  logic [deq_pkg::VAL_W-1:0] slots [deq_pkg::CAPACITY_DEF];
  logic [deq_pkg::POS_W-1:0] head;
  logic [deq_pkg::OCC_W-1:0] count;
  deque_result_t             pending_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Physical slot of a logical index; the 6-bit sum wraps around the ring.
  function automatic logic [deq_pkg::POS_W-1:0] slot_at(int idx);
    return head + deq_pkg::POS_W'(idx);
  endfunction

  task automatic apply_deque_op(input deq_pkg::op_t op,
                                input logic [deq_pkg::POS_W-1:0] pos,
                                input logic [deq_pkg::VAL_W-1:0] val,
                                output deque_result_t res);
    res = '{value: '0, occupancy: '0, status: deq_pkg::ST_OK};
    case (op)
      deq_pkg::OP_PUSH_BACK: begin
        if (count == FULL_COUNT) res.status = deq_pkg::ST_FULL;
        else begin
          slots[slot_at(int'(count))] = val;
          count++;
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        if (count == FULL_COUNT) res.status = deq_pkg::ST_FULL;
        else begin
          head--;
          slots[head] = val;
          count++;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (count == 0) res.status = deq_pkg::ST_EMPTY;
        else begin
          count--;
          res.value = slots[slot_at(int'(count))];
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (count == 0) res.status = deq_pkg::ST_EMPTY;
        else begin
          res.value = slots[head];
          head++;
          count--;
        end
      end
      deq_pkg::OP_READ: begin
        if (deq_pkg::OCC_W'(pos) >= count) res.status = deq_pkg::ST_RANGE;
        else res.value = slots[slot_at(int'(pos))];
      end
      deq_pkg::OP_WRITE: begin
        if (deq_pkg::OCC_W'(pos) >= count) res.status = deq_pkg::ST_RANGE;
        else slots[slot_at(int'(pos))] = val;
      end
      deq_pkg::OP_INSERT: begin
        if (count == FULL_COUNT) res.status = deq_pkg::ST_FULL;
        else if (deq_pkg::OCC_W'(pos) > count) res.status = deq_pkg::ST_RANGE;
        else begin
          // shift the tail back by one, starting from the end
          for (int i = int'(count); i > int'(pos); i--)
            slots[slot_at(i)] = slots[slot_at(i - 1)];
          slots[slot_at(int'(pos))] = val;
          count++;
        end
      end
      default: begin
        if (deq_pkg::OCC_W'(pos) >= count) res.status = deq_pkg::ST_RANGE;
        else begin
          res.value = slots[slot_at(int'(pos))];
          for (int i = int'(pos); i + 1 < int'(count); i++)
            slots[slot_at(i)] = slots[slot_at(i + 1)];
          count--;
        end
      end
    endcase
    res.occupancy = count;
  endtask

  always @(posedge clk) begin : watch
    deque_result_t want;
    deque_result_t got;
    if (!rst_n) begin
      head = '0;
      count = '0;
      pending_results.delete();
    end else begin
      // compare first: a new transfer may land on the same edge as a result
      if (out_valid) begin
        got = '{value: out_value_out, occupancy: out_occupancy,
                status: deq_pkg::status_t'(out_status)};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t unexpected deque result: value %h occupancy %0d status %0d",
                     $time, got.value, got.occupancy, got.status);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t deque result mismatch (expected/actual): value %h/%h %s%0d/%0d %s%0d/%0d",
                       $time, want.value, got.value, "occupancy ", want.occupancy,
                       got.occupancy, "status ", want.status, got.status);
          end
        end
      end
      if (start && !busy) begin
        apply_deque_op(deq_pkg::op_t'(in_opcode), in_position, in_value_in, want);
        pending_results = {pending_results, want};
      end
    end
    outstanding = pending_results.size();
  end

endmodule

@@ sim/double_ended_queue_unit_test.sv @@
`timescale 1ns / 1ps
module double_ended_queue_unit_test;

  localparam int RANDOM_ITEMS   = 1200;
  localparam int PHASE_ITEMS    = 150;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [deq_pkg::OP_W-1:0]  in_opcode;
  logic [deq_pkg::POS_W-1:0] in_position;
  logic [deq_pkg::VAL_W-1:0] in_value_in;
  logic                      out_valid;
  logic [deq_pkg::VAL_W-1:0] out_value_out;
  logic [deq_pkg::OCC_W-1:0] out_occupancy;
  logic [deq_pkg::ST_W-1:0]  out_status;
  int                        mismatches;
  int                        outstanding;

  int                        burst_left;
  int                        idle_cycles = 0;
  logic [deq_pkg::OCC_W-1:0] occ_seen = '0;

  double_ended_queue_unit DUT (.*);

  double_ended_queue_unit_checker checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Last occupancy seen on the result port; steers positions toward the live range.
  always @(posedge clk) begin
    if (out_valid) occ_seen <= out_occupancy;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Hold the command until the transfer, then maybe idle at the end of a burst.
  task automatic send_cmd(input deq_pkg::op_t op, input logic [deq_pkg::POS_W-1:0] pos,
                          input logic [deq_pkg::VAL_W-1:0] val);
    int gap;
    start       <= 1'b1;
    in_opcode   <= op;
    in_position <= pos;
    in_value_in <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  initial begin
    deq_pkg::op_t              op;
    logic [deq_pkg::POS_W-1:0] pos;
    logic [deq_pkg::VAL_W-1:0] val;
    int                        mode;
    int                        r;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_opcode   = '0;
    in_position = '0;
    in_value_in = '0;
    burst_left  = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue: every access is rejected
    send_cmd(deq_pkg::OP_POP_BACK, 6'd0, 32'h0);
    send_cmd(deq_pkg::OP_POP_FRONT, 6'd0, 32'h0);
    send_cmd(deq_pkg::OP_READ, 6'd0, 32'h0);
    send_cmd(deq_pkg::OP_WRITE, 6'd0, 32'hFFFF_FFFF);
    send_cmd(deq_pkg::OP_ERASE, 6'd0, 32'h0);
    send_cmd(deq_pkg::OP_INSERT, 6'd1, 32'h1111_1111);
    send_cmd(deq_pkg::OP_INSERT, 6'd63, 32'h2222_2222);
    // build up, wrapping the head below slot zero
    send_cmd(deq_pkg::OP_INSERT, 6'd0, 32'hFFFF_FFFF);
    send_cmd(deq_pkg::OP_PUSH_BACK, 6'd0, 32'h0);
    send_cmd(deq_pkg::OP_PUSH_FRONT, 6'd0, 32'h8000_0001);
    send_cmd(deq_pkg::OP_INSERT, 6'd3, 32'h1234_5678);
    send_cmd(deq_pkg::OP_INSERT, 6'd1, 32'hA5A5_A5A5);
    send_cmd(deq_pkg::OP_READ, 6'd0, 32'h0);
    send_cmd(deq_pkg::OP_READ, 6'd4, 32'h0);
    send_cmd(deq_pkg::OP_READ, 6'd5, 32'h0);
    send_cmd(deq_pkg::OP_READ, 6'd63, 32'h0);
    send_cmd(deq_pkg::OP_WRITE, 6'd2, 32'h5A5A_5A5A);
    send_cmd(deq_pkg::OP_WRITE, 6'd63, 32'h0);
    send_cmd(deq_pkg::OP_READ, 6'd2, 32'h0);
    // tear down: front, last and middle erase, then both pops
    send_cmd(deq_pkg::OP_ERASE, 6'd0, 32'h0);
    send_cmd(deq_pkg::OP_ERASE, 6'd3, 32'h0);
    send_cmd(deq_pkg::OP_ERASE, 6'd1, 32'h0);
    send_cmd(deq_pkg::OP_POP_BACK, 6'd0, 32'h0);
    send_cmd(deq_pkg::OP_POP_FRONT, 6'd0, 32'h0);
    send_cmd(deq_pkg::OP_POP_FRONT, 6'd0, 32'h0);

    // phases cycle grow, mixed, shrink so the queue hits both full and empty
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      mode = (n / PHASE_ITEMS) % 3;
      if (n == RANDOM_ITEMS / 2) drain_results();
      r = $urandom_range(0, 99);
      if (mode == 1) op = deq_pkg::op_t'($urandom_range(0, 7));
      else if (mode == 0) begin
        if (r < 28) op = deq_pkg::OP_PUSH_BACK;
        else if (r < 50) op = deq_pkg::OP_PUSH_FRONT;
        else if (r < 75) op = deq_pkg::OP_INSERT;
        else if (r < 80) op = deq_pkg::OP_POP_BACK;
        else if (r < 84) op = deq_pkg::OP_POP_FRONT;
        else if (r < 90) op = deq_pkg::OP_READ;
        else if (r < 96) op = deq_pkg::OP_WRITE;
        else op = deq_pkg::OP_ERASE;
      end else begin
        if (r < 5) op = deq_pkg::OP_PUSH_BACK;
        else if (r < 10) op = deq_pkg::OP_PUSH_FRONT;
        else if (r < 15) op = deq_pkg::OP_INSERT;
        else if (r < 38) op = deq_pkg::OP_POP_BACK;
        else if (r < 60) op = deq_pkg::OP_POP_FRONT;
        else if (r < 70) op = deq_pkg::OP_READ;
        else if (r < 78) op = deq_pkg::OP_WRITE;
        else op = deq_pkg::OP_ERASE;
      end
      if ($urandom_range(0, 4) == 0 || occ_seen == 0)
        pos = deq_pkg::POS_W'($urandom_range(0, 63));
      else pos = (occ_seen > 63) ? deq_pkg::POS_W'($urandom_range(0, 63))
                                 : deq_pkg::POS_W'($urandom_range(0, int'(occ_seen)));
      case ($urandom_range(0, 7))
        0: val = '0;
        1: val = '1;
        default: val = $urandom;
      endcase
      send_cmd(op, pos, val);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ double_ended_queue_unit.f @@
+incdir+hw/rtl
hw/rtl/deq_pkg.sv
hw/rtl/deq_ram.sv
hw/rtl/deq_ctrl.sv
hw/rtl/deq_dp.sv
hw/rtl/double_ended_queue_unit.sv
hw/rtl/deq_chk.sv
sim/double_ended_queue_unit_checker.sv
sim/double_ended_queue_unit_test.sv
